[rtl/core/lbm_pkg.sv]
// Shared types, constants and helper functions of the D2Q9 buoyant collision block.
`timescale 1ns / 1ps
`default_nettype none

package lbm_pkg;

    localparam int COORD_BITS = 10;
    localparam int DIV_STAGES = 33;
    localparam int POST_STAGES = 9;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic signed [63:0] Q_ONE = 64'sd16777216;
    localparam logic signed [63:0] Q_HALF = 64'sd8388608;

    // Equilibrium weights in Q8.24: rest, axis, diagonal.
    localparam logic signed [31:0] W_VAL [0:2] = '{32'sd7456540, 32'sd1864135, 32'sd466034};
    localparam logic signed [31:0] W3_AXIS = 32'sd5592405;
    localparam logic signed [31:0] W3_DIAG = 32'sd1398102;

    localparam int DIR_CX [0:8] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int DIR_CY [0:8] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam int W_SEL [0:8] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};
    localparam int F_SEL [0:8] = '{0, 0, 0, 0, 0, 1, 1, 1, 1};

    typedef enum logic [2:0] {
        CFG_RELAX    = 3'd0,
        CFG_GAIN     = 3'd1,
        CFG_LAST_COL = 3'd2,
        CFG_LAST_ROW = 3'd3
    } t_cfg_index;

    typedef struct packed {
        logic [25:0] relax_rate;
        logic [31:0] buoyancy_gain;
        logic [9:0]  last_column;
        logic [9:0]  last_row;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pop_rest;
        logic signed [31:0] pop_east;
        logic signed [31:0] pop_north;
        logic signed [31:0] pop_west;
        logic signed [31:0] pop_south;
        logic signed [31:0] pop_northeast;
        logic signed [31:0] pop_northwest;
        logic signed [31:0] pop_southwest;
        logic signed [31:0] pop_southeast;
        logic signed [31:0] temperature;
        logic [COORD_BITS-1:0] cell_x;
        logic [COORD_BITS-1:0] cell_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] out_rest;
        logic signed [31:0] out_east;
        logic signed [31:0] out_north;
        logic signed [31:0] out_west;
        logic signed [31:0] out_south;
        logic signed [31:0] out_northeast;
        logic signed [31:0] out_northwest;
        logic signed [31:0] out_southwest;
        logic signed [31:0] out_southeast;
        logic signed [31:0] density;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
    } t_out_word;

    // Classified cell as it waits in the queue between front and back.
    typedef struct packed {
        logic [8:0][31:0]   f;
        logic signed [31:0] rho;
        logic signed [31:0] buoy0;
        logic [39:0]        abs_x;
        logic [39:0]        abs_y;
        logic               rho_pos;
        logic               neg_x;
        logic               neg_y;
        logic               ov_x;
        logic               ov_y;
        logic               border;
    } t_cell;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sd2147483647) begin
            y = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic signed [63:0] sx(input logic signed [31:0] a);
        return 64'(a);
    endfunction

endpackage

`default_nettype wire

[rtl/core/lbm_in_if.sv]
// Input channel carrying one lattice cell word.
`timescale 1ns / 1ps
`default_nettype none

interface lbm_in_if;
    logic               valid;
    logic               ready;
    lbm_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/lbm_out_if.sv]
// Output channel carrying one relaxed cell word.
`timescale 1ns / 1ps
`default_nettype none

interface lbm_out_if;
    logic               valid;
    logic               ready;
    lbm_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/lbm_front.sv]
// Front end: accepts cell words, forms moments, density, border flag and buoyancy offset.
`timescale 1ns / 1ps
`default_nettype none

module lbm_front (
    lbm_in_if.sink          i_in,
    input  lbm_pkg::t_cfg   i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output lbm_pkg::t_cell  o_cell
);

    logic signed [31:0] f [9];
    logic signed [39:0] s_sum;
    logic signed [39:0] s_mx;
    logic signed [39:0] s_my;
    logic signed [31:0] s_rho;
    logic [lbm_pkg::COORD_BITS-1:0] s_lc;
    logic [lbm_pkg::COORD_BITS-1:0] s_lr;

    assign i_in.ready = !i_full;
    assign o_push = i_in.valid && !i_full;

    assign f[0] = i_in.data.pop_rest;
    assign f[1] = i_in.data.pop_east;
    assign f[2] = i_in.data.pop_north;
    assign f[3] = i_in.data.pop_west;
    assign f[4] = i_in.data.pop_south;
    assign f[5] = i_in.data.pop_northeast;
    assign f[6] = i_in.data.pop_northwest;
    assign f[7] = i_in.data.pop_southwest;
    assign f[8] = i_in.data.pop_southeast;

    always_comb begin
        s_sum = '0;
        for (int k = 0; k < 9; k++) begin
            s_sum = s_sum + 40'(f[k]);
        end
        s_mx = 40'(f[1]) - 40'(f[3]) + 40'(f[5]) - 40'(f[6]) - 40'(f[7]) + 40'(f[8]);
        s_my = 40'(f[2]) - 40'(f[4]) + 40'(f[5]) + 40'(f[6]) - 40'(f[7]) - 40'(f[8]);
        s_rho = lbm_pkg::sat32(64'(s_sum));
        s_lc = lbm_pkg::COORD_BITS'(i_cfg.last_column);
        s_lr = lbm_pkg::COORD_BITS'(i_cfg.last_row);

        for (int k = 0; k < 9; k++) begin
            o_cell.f[k] = f[k];
        end
        o_cell.rho = s_rho;
        o_cell.rho_pos = !s_rho[31] && (s_rho != 32'sd0);
        o_cell.neg_x = s_mx[39];
        o_cell.neg_y = s_my[39];
        o_cell.abs_x = s_mx[39] ? 40'(-s_mx) : 40'(s_mx);
        o_cell.abs_y = s_my[39] ? 40'(-s_my) : 40'(s_my);
        // The quotient overflows 33 bits when |m| >= rho * 2^9.
        o_cell.ov_x = 41'(o_cell.abs_x) >= {s_rho, 9'b0};
        o_cell.ov_y = 41'(o_cell.abs_y) >= {s_rho, 9'b0};
        o_cell.buoy0 = lbm_pkg::sat32(lbm_pkg::sx(i_in.data.temperature) - lbm_pkg::Q_HALF);
        o_cell.border = (i_in.data.cell_x == '0) || (i_in.data.cell_x == s_lc) ||
                        (i_in.data.cell_y == '0) || (i_in.data.cell_y == s_lr);
    end

endmodule

`default_nettype wire

[rtl/core/lbm_fifo.sv]
// Short queue of classified cells between the front end and the collision pipeline.
`timescale 1ns / 1ps
`default_nettype none

module lbm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbm_pkg::t_cell  i_data,
    input  logic            i_pop,
    output lbm_pkg::t_cell  o_data,
    output logic            o_empty,
    output logic            o_full
);

    lbm_pkg::t_cell r_mem [lbm_pkg::FIFO_DEPTH];
    logic [lbm_pkg::FIFO_AW-1:0] r_wp;
    logic [lbm_pkg::FIFO_AW-1:0] r_rp;
    logic [lbm_pkg::FIFO_AW:0]   r_count;

    assign o_data = r_mem[r_rp];
    assign o_empty = (r_count == '0);
    assign o_full = (r_count == (lbm_pkg::FIFO_AW + 1)'(lbm_pkg::FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue read while empty");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_push) && !$past(i_pop)) |-> !o_empty)
        else $error("word lost after push");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_push) && !$past(i_pop)) |-> $stable(r_count))
        else $error("queue count moved without traffic");

endmodule

`default_nettype wire

[rtl/core/lbm_back.sv]
// Collision pipeline: restoring velocity dividers, equilibrium, relaxation and buoyancy force.
`timescale 1ns / 1ps
`default_nettype none

module lbm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lbm_pkg::t_cfg   i_cfg,
    input  logic            i_empty,
    input  lbm_pkg::t_cell  i_cell,
    output logic            o_pop,
    lbm_out_if.source       o_out
);

    localparam int DS = lbm_pkg::DIV_STAGES;
    localparam int PS = lbm_pkg::POST_STAGES;

    typedef struct packed {
        lbm_pkg::t_cell c;
        logic [63:0]    rem_x;
        logic [63:0]    rem_y;
        logic [32:0]    q_x;
        logic [32:0]    q_y;
    } t_div;

    typedef struct packed {
        logic [8:0][31:0]   f;
        logic signed [31:0] rho;
        logic signed [31:0] buoy0;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               border;
        logic signed [63:0] pu;
        logic signed [63:0] pv;
        logic signed [63:0] bg;
        logic signed [31:0] t1;
        logic signed [31:0] bb;
        logic [8:0][31:0]   t2;
        logic [8:0][63:0]   sqp;
        logic signed [63:0] bfp;
        logic [2:0][63:0]   rwp;
        logic [8:0][31:0]   poly;
        logic signed [31:0] buoy;
        logic [2:0][31:0]   rw;
        logic [8:0][63:0]   feqp;
        logic [8:0][63:0]   fp;
        logic [1:0][63:0]   forcep;
        logic [8:0][31:0]   feq;
        logic [8:0][32:0]   frc;
        logic [8:0][39:0]   fpart;
        logic [8:0][63:0]   gp;
        logic [8:0][31:0]   res;
    } t_post;

    t_div  r_dv [DS];
    t_div  n_dv [DS];
    t_post r_ps [PS];
    t_post n_ps [PS];
    logic [DS-1:0] r_dv_vld;
    logic [PS-1:0] r_ps_vld;
    logic          adv;
    logic signed [63:0] om;

    // One quotient bit per stage, most significant first.
    function automatic t_div div_step(input t_div x, input int unsigned b);
        t_div y;
        logic [63:0] d;
        y = x;
        d = {32'b0, x.c.rho} << b;
        if (x.rem_x >= d) begin
            y.rem_x = x.rem_x - d;
            y.q_x = x.q_x | (33'd1 << b);
        end
        if (x.rem_y >= d) begin
            y.rem_y = x.rem_y - d;
            y.q_y = x.q_y | (33'd1 << b);
        end
        return y;
    endfunction

    function automatic logic signed [31:0] quot(input logic pos, input logic neg,
                                                input logic ov, input logic [32:0] q);
        logic signed [31:0] y;
        if (!pos) begin
            y = '0;
        end else if (neg) begin
            y = (ov || q > 33'h080000000) ? 32'sh80000000 : -$signed(q[31:0]);
        end else begin
            y = (ov || q >= 33'h100000000 >> 1) ? 32'sh7fffffff : $signed(q[31:0]);
        end
        return y;
    endfunction

    assign adv = !r_ps_vld[PS-1] || o_out.ready;
    assign o_pop = adv && !i_empty;
    assign om = $signed({38'b0, i_cfg.relax_rate});

    always_comb begin
        t_div init;
        init.c = i_cell;
        init.rem_x = {i_cell.abs_x, 24'b0};
        init.rem_y = {i_cell.abs_y, 24'b0};
        init.q_x = '0;
        init.q_y = '0;
        n_dv[0] = div_step(init, 32);
        for (int s = 1; s < DS; s++) begin
            n_dv[s] = div_step(r_dv[s-1], 32 - s);
        end
    end

    // Velocities, their squares and the buoyancy product.
    always_comb begin
        t_div  d;
        t_post p;
        d = r_dv[DS-1];
        p = '0;
        p.f = d.c.f;
        p.rho = d.c.rho;
        p.buoy0 = d.c.buoy0;
        p.border = d.c.border;
        p.u = quot(d.c.rho_pos, d.c.neg_x, d.c.ov_x, d.q_x);
        p.v = quot(d.c.rho_pos, d.c.neg_y, d.c.ov_y, d.q_y);
        n_ps[0] = p;

        p = r_ps[0];
        p.pu = lbm_pkg::sx(p.u) * lbm_pkg::sx(p.u);
        p.pv = lbm_pkg::sx(p.v) * lbm_pkg::sx(p.v);
        p.bg = lbm_pkg::sx(p.buoy0) * $signed({32'b0, i_cfg.buoyancy_gain});
        n_ps[1] = p;
    end

    // Speed terms and direction projections.
    always_comb begin
        t_post p;
        p = r_ps[1];
        p.t1 = lbm_pkg::sat32((p.pu >>> 24) + (p.pv >>> 24));
        p.bb = lbm_pkg::sat32(p.bg >>> 32);
        for (int k = 0; k < 9; k++) begin
            p.t2[k] = lbm_pkg::sat32(lbm_pkg::sx(p.u) * 64'(lbm_pkg::DIR_CX[k]) +
                                     lbm_pkg::sx(p.v) * 64'(lbm_pkg::DIR_CY[k]));
        end
        n_ps[2] = p;
    end

    always_comb begin
        t_post p;
        p = r_ps[2];
        for (int k = 0; k < 9; k++) begin
            p.sqp[k] = lbm_pkg::sx($signed(p.t2[k])) * lbm_pkg::sx($signed(p.t2[k]));
        end
        p.bfp = lbm_pkg::sx(p.bb) * lbm_pkg::sx(p.rho);
        for (int j = 0; j < 3; j++) begin
            p.rwp[j] = lbm_pkg::sx(p.rho) * lbm_pkg::sx(lbm_pkg::W_VAL[j]);
        end
        n_ps[3] = p;
    end

    // Equilibrium polynomial, weighted density and the force base.
    always_comb begin
        t_post p;
        logic signed [63:0] sq;
        logic signed [63:0] acc;
        p = r_ps[3];
        for (int k = 0; k < 9; k++) begin
            sq = lbm_pkg::sx(lbm_pkg::sat32($signed(p.sqp[k]) >>> 24));
            acc = lbm_pkg::Q_ONE + 64'sd3 * lbm_pkg::sx($signed(p.t2[k]))
                + ((64'sd9 * sq) >>> 1) - ((64'sd3 * lbm_pkg::sx(p.t1)) >>> 1);
            p.poly[k] = lbm_pkg::sat32(acc);
        end
        p.buoy = lbm_pkg::sat32(p.bfp >>> 24);
        for (int j = 0; j < 3; j++) begin
            p.rw[j] = lbm_pkg::sat32($signed(p.rwp[j]) >>> 24);
        end
        n_ps[4] = p;
    end

    always_comb begin
        t_post p;
        p = r_ps[4];
        for (int k = 0; k < 9; k++) begin
            p.feqp[k] = lbm_pkg::sx($signed(p.rw[lbm_pkg::W_SEL[k]])) *
                        lbm_pkg::sx($signed(p.poly[k]));
            p.fp[k] = (lbm_pkg::Q_ONE - om) * lbm_pkg::sx($signed(p.f[k]));
        end
        p.forcep[0] = lbm_pkg::sx(p.buoy) * lbm_pkg::sx(lbm_pkg::W3_AXIS);
        p.forcep[1] = lbm_pkg::sx(p.buoy) * lbm_pkg::sx(lbm_pkg::W3_DIAG);
        n_ps[5] = p;
    end

    // Force is pushed up along north-going directions and down along south-going ones, and is zero on border cells.
    always_comb begin
        t_post p;
        logic signed [32:0] fr;
        p = r_ps[5];
        for (int k = 0; k < 9; k++) begin
            p.feq[k] = lbm_pkg::sat32($signed(p.feqp[k]) >>> 24);
            p.fpart[k] = 40'($signed(p.fp[k]) >>> 24);
            fr = 33'(lbm_pkg::sat32($signed(p.forcep[lbm_pkg::F_SEL[k]]) >>> 24));
            if (p.border || lbm_pkg::DIR_CY[k] == 0) begin
                p.frc[k] = '0;
            end else if (lbm_pkg::DIR_CY[k] < 0) begin
                p.frc[k] = -fr;
            end else begin
                p.frc[k] = fr;
            end
        end
        n_ps[6] = p;
    end

    always_comb begin
        t_post p;
        p = r_ps[6];
        for (int k = 0; k < 9; k++) begin
            p.gp[k] = om * lbm_pkg::sx($signed(p.feq[k]));
        end
        n_ps[7] = p;
    end

    always_comb begin
        t_post p;
        p = r_ps[7];
        for (int k = 0; k < 9; k++) begin
            p.res[k] = lbm_pkg::sat32(($signed(p.gp[k]) >>> 24) +
                                      64'($signed(p.fpart[k])) + 64'($signed(p.frc[k])));
        end
        n_ps[8] = p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= '0;
            r_ps_vld <= '0;
        end else if (adv) begin
            r_dv_vld <= {r_dv_vld[DS-2:0], o_pop};
            r_ps_vld <= {r_ps_vld[PS-2:0], r_dv_vld[DS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv <= n_dv;
            r_ps <= n_ps;
        end
    end

    assign o_out.valid = r_ps_vld[PS-1];
    assign o_out.data.out_rest = $signed(r_ps[PS-1].res[0]);
    assign o_out.data.out_east = $signed(r_ps[PS-1].res[1]);
    assign o_out.data.out_north = $signed(r_ps[PS-1].res[2]);
    assign o_out.data.out_west = $signed(r_ps[PS-1].res[3]);
    assign o_out.data.out_south = $signed(r_ps[PS-1].res[4]);
    assign o_out.data.out_northeast = $signed(r_ps[PS-1].res[5]);
    assign o_out.data.out_northwest = $signed(r_ps[PS-1].res[6]);
    assign o_out.data.out_southwest = $signed(r_ps[PS-1].res[7]);
    assign o_out.data.out_southeast = $signed(r_ps[PS-1].res[8]);
    assign o_out.data.density = r_ps[PS-1].rho;
    assign o_out.data.velocity_x = r_ps[PS-1].u;
    assign o_out.data.velocity_y = r_ps[PS-1].v;

endmodule

`default_nettype wire

[rtl/core/lbm_d2q9_buoyant_collision.sv]
// Top level of the D2Q9 BGK collision with Boussinesq buoyancy.
// Throughput is one cell word per cycle unless the output stalls.
// The 33-stage restoring divider sets most of the pipeline depth.
// A 4-entry queue sits between the front end and the pipeline, which stalls as a whole.
// Synchronous active-low reset empties the queue and pipeline and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module lbm_d2q9_buoyant_collision (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    lbm_in_if.sink      i_in,
    lbm_out_if.source   o_out
);

    lbm_pkg::t_cfg  r_cfg;
    lbm_pkg::t_cell s_cell;
    lbm_pkg::t_cell s_head;
    logic           s_push;
    logic           s_pop;
    logic           s_empty;
    logic           s_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relax_rate <= 26'd29959314;
            r_cfg.buoyancy_gain <= 32'd241970;
            r_cfg.last_column <= 10'd100;
            r_cfg.last_row <= 10'd100;
        end else if (i_cfg_we) begin
            unique case (lbm_pkg::t_cfg_index'(i_cfg_index))
                lbm_pkg::CFG_RELAX: r_cfg.relax_rate <= i_cfg_data[25:0];
                lbm_pkg::CFG_GAIN: r_cfg.buoyancy_gain <= i_cfg_data;
                lbm_pkg::CFG_LAST_COL: r_cfg.last_column <= i_cfg_data[9:0];
                lbm_pkg::CFG_LAST_ROW: r_cfg.last_row <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    lbm_front u_front (
        .i_in   (i_in),
        .i_cfg  (r_cfg),
        .i_full (s_full),
        .o_push (s_push),
        .o_cell (s_cell)
    );

    lbm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_cell),
        .i_pop   (s_pop),
        .o_data  (s_head),
        .o_empty (s_empty),
        .o_full  (s_full)
    );

    lbm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (s_empty),
        .i_cell  (s_head),
        .o_pop   (s_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[dv/tb_lbm_d2q9_buoyant_collision.sv]
// Self-checking testbench for the D2Q9 buoyant collision block with random stimulus and stalls.
`timescale 1ns / 1ps

module tb_lbm_d2q9_buoyant_collision;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    lbm_in_if  cell_ch ();
    lbm_out_if relaxed_ch ();

    lbm_d2q9_buoyant_collision u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (cell_ch.sink),
        .o_out       (relaxed_ch.source)
    );

    // Register copies used by the collision predictor.
    logic [25:0] omega_q;
    logic [31:0] gain_q;
    logic [9:0]  col_limit;
    logic [9:0]  row_limit;

    lbm_pkg::t_out_word pending_cells[$];
    int        error_count;
    int        cells_sent;
    int        cells_checked;
    bit        quiet;        // no idling on either side
    bit        hold_output;  // long receiver hold-off

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint q24_mul(longint a, longint b);
        return (a * b) >>> 24;
    endfunction

    function automatic lbm_pkg::t_out_word predict_cell(lbm_pkg::t_in_word c);
        longint f[9];
        longint sum, mx, my, rho, u, v, t1, buoy, t2, sq, poly, rw, feq, frc, r, w;
        logic [0:11][31:0] res;
        bit border;
        int k;
        f[0] = c.pop_rest;      f[1] = c.pop_east;      f[2] = c.pop_north;
        f[3] = c.pop_west;      f[4] = c.pop_south;     f[5] = c.pop_northeast;
        f[6] = c.pop_northwest; f[7] = c.pop_southwest; f[8] = c.pop_southeast;
        sum = 0; mx = 0; my = 0; u = 0; v = 0;
        for (k = 0; k < 9; k++) begin
            sum += f[k];
            mx += f[k] * lbm_pkg::DIR_CX[k];
            my += f[k] * lbm_pkg::DIR_CY[k];
        end
        rho = clamp32(sum);
        if (rho > 0) begin
            u = clamp32((mx * lbm_pkg::Q_ONE) / rho);
            v = clamp32((my * lbm_pkg::Q_ONE) / rho);
        end
        border = c.cell_x == 0 || c.cell_x == col_limit ||
                 c.cell_y == 0 || c.cell_y == row_limit;
        buoy = clamp32(longint'(c.temperature) - lbm_pkg::Q_HALF);
        buoy = clamp32((buoy * longint'({32'd0, gain_q})) >>> 32);
        buoy = clamp32(q24_mul(buoy, rho));
        t1 = clamp32(q24_mul(u, u) + q24_mul(v, v));
        for (k = 0; k < 9; k++) begin
            w = lbm_pkg::W_VAL[lbm_pkg::W_SEL[k]];
            t2 = clamp32(u * lbm_pkg::DIR_CX[k] + v * lbm_pkg::DIR_CY[k]);
            sq = clamp32(q24_mul(t2, t2));
            poly = clamp32(lbm_pkg::Q_ONE + 3 * t2 + ((9 * sq) >>> 1) - ((3 * t1) >>> 1));
            rw = clamp32(q24_mul(rho, w));
            feq = clamp32(q24_mul(rw, poly));
            frc = 0;
            if (!border && lbm_pkg::DIR_CY[k] != 0) begin
                frc = clamp32(q24_mul(3 * w, buoy));
                if (lbm_pkg::DIR_CY[k] < 0) frc = -frc;
            end
            r = q24_mul(longint'(omega_q), feq)
              + q24_mul(lbm_pkg::Q_ONE - longint'(omega_q), f[k]) + frc;
            res[k] = clamp32(r);
        end
        res[9] = rho;
        res[10] = u;
        res[11] = v;
        return lbm_pkg::t_out_word'(res);
    endfunction

    task automatic write_reg(lbm_pkg::t_cfg_index idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        case (idx)
            lbm_pkg::CFG_RELAX:    omega_q = value[25:0];
            lbm_pkg::CFG_GAIN:     gain_q = value;
            lbm_pkg::CFG_LAST_COL: col_limit = value[9:0];
            lbm_pkg::CFG_LAST_ROW: row_limit = value[9:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] omega, logic [31:0] gain, logic [9:0] lc, logic [9:0] lr);
        drain();
        write_reg(lbm_pkg::CFG_RELAX, omega);
        write_reg(lbm_pkg::CFG_GAIN, gain);
        write_reg(lbm_pkg::CFG_LAST_COL, {22'd0, lc});
        write_reg(lbm_pkg::CFG_LAST_ROW, {22'd0, lr});
    endtask

    // Offers one word at the falling edge and holds it until it is taken.
    task automatic send_cell(lbm_pkg::t_in_word c);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            cell_ch.valid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge i_clk);
        end
        cell_ch.valid = 1'b1;
        cell_ch.data = c;
        do @(posedge i_clk); while (!cell_ch.ready);
        pending_cells.push_back(predict_cell(c));
        cells_sent++;
        @(negedge i_clk);
        cell_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] near_pop(int scale);
        return (32'd1864135 + $urandom_range(0, 2 * scale) - scale);
    endfunction

    function automatic logic [9:0] pick_coord(logic [9:0] lim);
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return lim;
            2: return 10'($urandom);
            default: return 10'($urandom_range(1, (lim > 1) ? lim - 1 : 1));
        endcase
    endfunction

    function automatic lbm_pkg::t_in_word random_cell();
        lbm_pkg::t_in_word c;
        logic [0:9][31:0] v;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 10; k++) begin
            if (mode == 0) v[k] = $urandom;
            else if (mode == 1) v[k] = 32'($urandom_range(0, 4000000)) - 32'd2000000;
            else v[k] = near_pop((mode < 6) ? 300000 : 1500000);
        end
        if (mode >= 2) v[9] = 32'd8388608 + 32'($urandom_range(0, 16777216)) - 32'd8388608;
        if (mode == 9) v[9] = $urandom;
        c = lbm_pkg::t_in_word'({v, 20'd0});
        c.cell_x = pick_coord(col_limit);
        c.cell_y = pick_coord(row_limit);
        return c;
    endfunction

    function automatic lbm_pkg::t_in_word flat_cell(logic [31:0] pop, logic [31:0] temp,
                                                    logic [9:0] x, logic [9:0] y);
        logic [0:9][31:0] v;
        for (int k = 0; k < 9; k++) v[k] = pop;
        v[9] = temp;
        return lbm_pkg::t_in_word'({v, x, y});
    endfunction

    // Word checker and receiver ready.
    always @(posedge i_clk) begin
        lbm_pkg::t_out_word exp_w;
        logic [0:11][31:0] e, a;
        string names[12];
        names = '{"out_rest", "out_east", "out_north", "out_west", "out_south",
                  "out_northeast", "out_northwest", "out_southwest", "out_southeast",
                  "density", "velocity_x", "velocity_y"};
        if (i_rst_n && relaxed_ch.valid && relaxed_ch.ready) begin
            if (pending_cells.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                exp_w = pending_cells.pop_front();
                e = exp_w;
                a = relaxed_ch.data;
                for (int k = 0; k < 12; k++) begin
                    if (e[k] !== a[k]) begin
                        $error("%s: expected %h, got %h", names[k], e[k], a[k]);
                        error_count++;
                    end
                end
                cells_checked++;
            end
        end
    end

    initial begin
        int n;
        relaxed_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                relaxed_ch.ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                relaxed_ch.ready = 1'b0;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                relaxed_ch.ready = 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_cell(flat_cell(32'd0, 32'd0, 10'd5, 10'd5));
        send_cell(flat_cell(32'h7fffffff, 32'h7fffffff, 10'd5, 10'd5));
        send_cell(flat_cell(32'h80000000, 32'h80000000, 10'd5, 10'd5));
        send_cell(flat_cell(32'hff000000, 32'd8388608, 10'd7, 10'd9));
        send_cell(flat_cell(32'd1864135, 32'd8388608, 10'd5, 10'd5));
        send_cell(flat_cell(32'd1864135, 32'd16777216, 10'd0, 10'd5));
        send_cell(flat_cell(32'd1864135, 32'd16777216, col_limit, 10'd5));
        send_cell(flat_cell(32'd1864135, 32'd16777216, 10'd5, 10'd0));
        send_cell(flat_cell(32'd1864135, 32'd16777216, 10'd5, row_limit));
        send_cell(flat_cell(32'd1864135, 32'd16777216, 10'd1023, 10'd1023));
        send_cell(flat_cell(32'd1864135, 32'h7fffffff, 10'd3, 10'd4));
        send_cell(flat_cell(32'd1864135, 32'h80000000, 10'd3, 10'd4));
        for (int k = 0; k < 8; k++) send_cell(random_cell());
    endtask

    task automatic test_config_extremes();
        set_regs(32'd0, 32'd0, 10'd1, 10'd1);
        test_directed();
        set_regs(32'd33554432, 32'hffffffff, 10'd1023, 10'd1023);
        test_directed();
        set_regs(32'h03ffffff, 32'h80000000, 10'd1, 10'd1023);
        test_directed();
        set_regs(32'd29959314, 32'd241970, 10'd100, 10'd100);
    endtask

    task automatic test_backpressure();
        hold_output = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_output = 1'b0;
            end
            for (int k = 0; k < 80; k++) send_cell(random_cell());
        join
    endtask

    task automatic test_random(int count, bit calm);
        quiet = calm;
        for (int k = 0; k < count; k++) send_cell(random_cell());
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 4; p++) begin
            set_regs($urandom_range(0, 33554432), $urandom, 10'($urandom_range(1, 1023)),
                     10'($urandom_range(1, 1023)));
            test_random(200, 1'b0);
        end
    endtask

    initial begin
        error_count = 0;
        cells_sent = 0;
        cells_checked = 0;
        quiet = 1'b0;
        hold_output = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = lbm_pkg::CFG_RELAX;
        i_cfg_data = 32'd0;
        cell_ch.valid = 1'b0;
        cell_ch.data = '0;
        omega_q = 26'd29959314;
        gain_q = 32'd241970;
        col_limit = 10'd100;
        row_limit = 10'd100;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_random(300, 1'b0);
        test_backpressure();
        test_random_settings();
        test_random(300, 1'b1);
        drain();

        $display("Sent %0d cells, checked %0d result words, over several register settings,",
                 cells_sent, cells_checked);
        $display("with border cells, zero and negative density, saturation and stalls.");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
